// File: rtl/mdss_pkg.sv
// Package for the multiplexed display scan serializer.
// Holds the geometry constants, operation codes and the scan entry type.
// No dependencies.
package mdss_pkg;

  localparam int NUM_COMMONS = 5;
  localparam int WORD_BITS   = 16;
  localparam int NUM_GROUPS  = 3;

  localparam int OP_W        = 2;
  localparam int WORD_IDX_W  = 4;
  localparam int VALUE_W     = 16;
  localparam int SEL_W       = 3;

  localparam int IDX_W       = (NUM_COMMONS > 1) ? $clog2(NUM_COMMONS) : 1;
  localparam int TOTAL_BITS  = NUM_GROUPS * WORD_BITS;
  localparam int CNT_W       = $clog2(TOTAL_BITS);
  localparam int FIFO_DEPTH  = 2;
  localparam int PTR_W       = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W      = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_COMMIT = 2'd1,
    OP_TICK   = 2'd2
  } op_e;

  // One refresh: inverted words, group 0 in the low bits, and its common line.
  typedef struct packed {
    logic [NUM_GROUPS-1:0][WORD_BITS-1:0] words;
    logic [IDX_W-1:0]                     common;
  } scan_t;

endpackage

// File: rtl/mdss_front.sv
// Front part: decodes operations, owns back/front buffers, index and pending flag.
// Emits one scan entry per refresh tick. Depends on mdss_pkg.
module mdss_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               accept_i,
  input  logic [mdss_pkg::OP_W-1:0]          operation_i,
  input  logic [mdss_pkg::WORD_IDX_W-1:0]    word_index_i,
  input  logic [mdss_pkg::VALUE_W-1:0]       word_value_i,
  output logic                               entry_valid_o,
  output mdss_pkg::scan_t                    entry_o
);

  logic [mdss_pkg::WORD_BITS-1:0] back_q  [mdss_pkg::NUM_GROUPS][mdss_pkg::NUM_COMMONS];
  logic [mdss_pkg::WORD_BITS-1:0] front_q [mdss_pkg::NUM_GROUPS][mdss_pkg::NUM_COMMONS];
  logic [mdss_pkg::IDX_W-1:0]     idx_q;
  logic [mdss_pkg::IDX_W-1:0]     idx_nxt;
  logic                           pending_q;
  mdss_pkg::op_e                  op;

  assign op = mdss_pkg::op_e'(operation_i);

  always_comb begin
    if (idx_q == mdss_pkg::IDX_W'(mdss_pkg::NUM_COMMONS - 1)) begin
      idx_nxt = '0;
    end else begin
      idx_nxt = idx_q + mdss_pkg::IDX_W'(1);
    end
  end

  // Words for the new index; a pending update is seen through the back buffer.
  always_comb begin
    entry_o.common = idx_nxt;
    for (int g = 0; g < mdss_pkg::NUM_GROUPS; g++) begin
      if (pending_q) begin
        entry_o.words[g] = ~back_q[g][idx_nxt];
      end else begin
        entry_o.words[g] = ~front_q[g][idx_nxt];
      end
    end
  end

  assign entry_valid_o = accept_i && (op == mdss_pkg::OP_TICK);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      pending_q <= 1'b0;
      for (int g = 0; g < mdss_pkg::NUM_GROUPS; g++) begin
        for (int c = 0; c < mdss_pkg::NUM_COMMONS; c++) begin
          back_q[g][c]  <= '0;
          front_q[g][c] <= '0;
        end
      end
    end else if (accept_i) begin
      case (op)
        mdss_pkg::OP_WRITE: begin
          for (int g = 0; g < mdss_pkg::NUM_GROUPS; g++) begin
            for (int c = 0; c < mdss_pkg::NUM_COMMONS; c++) begin
              if (word_index_i ==
                  mdss_pkg::WORD_IDX_W'(g * mdss_pkg::NUM_COMMONS + c)) begin
                back_q[g][c] <= mdss_pkg::WORD_BITS'(word_value_i);
              end
            end
          end
        end
        mdss_pkg::OP_COMMIT: begin
          pending_q <= 1'b1;
        end
        mdss_pkg::OP_TICK: begin
          if (pending_q) begin
            front_q   <= back_q;
            pending_q <= 1'b0;
          end
          idx_q <= idx_nxt;
        end
        default: begin
        end
      endcase
    end
  end

  a_tick_clears_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    entry_valid_o |=> !pending_q)
    else $error("pending flag survived a tick");

  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q < mdss_pkg::IDX_W'(mdss_pkg::NUM_COMMONS))
    else $error("common index out of range");

endmodule

// File: rtl/mdss_fifo.sv
// Short queue of scan entries between the front and back parts.
// Depends on mdss_pkg.
module mdss_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            wr_i,
  input  mdss_pkg::scan_t wr_data_i,
  output logic            full_o,
  input  logic            rd_i,
  output logic            valid_o,
  output mdss_pkg::scan_t rd_data_o
);

  mdss_pkg::scan_t                mem_q [mdss_pkg::FIFO_DEPTH];
  logic [mdss_pkg::PTR_W-1:0]     wr_ptr_q;
  logic [mdss_pkg::PTR_W-1:0]     rd_ptr_q;
  logic [mdss_pkg::FILL_W-1:0]    fill_q;
  logic                           do_wr;
  logic                           do_rd;

  assign full_o    = (fill_q == mdss_pkg::FILL_W'(mdss_pkg::FIFO_DEPTH));
  assign valid_o   = (fill_q != '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == mdss_pkg::PTR_W'(mdss_pkg::FIFO_DEPTH - 1)) ? '0
                    : wr_ptr_q + mdss_pkg::PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == mdss_pkg::PTR_W'(mdss_pkg::FIFO_DEPTH - 1)) ? '0
                    : rd_ptr_q + mdss_pkg::PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill_q <= fill_q + mdss_pkg::FILL_W'(1);
      end else if (do_rd && !do_wr) begin
        fill_q <= fill_q - mdss_pkg::FILL_W'(1);
      end
    end
  end

  a_no_write_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !wr_i)
    else $error("entry pushed into full queue");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= mdss_pkg::FILL_W'(mdss_pkg::FIFO_DEPTH))
    else $error("queue fill count overflow");

endmodule

// File: rtl/mdss_back.sv
// Back part: shifts one scan entry out as serial bits, one beat per bit.
// Depends on mdss_pkg.
module mdss_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         entry_valid_i,
  input  mdss_pkg::scan_t              entry_i,
  output logic                         entry_rd_o,
  output logic                         empty,
  input  logic                         pop,
  output logic                         serial_bit_o,
  output logic [mdss_pkg::SEL_W-1:0]   common_select_o,
  output logic                         last_o
);

  logic [mdss_pkg::TOTAL_BITS-1:0] shift_q, shift_d;
  logic [mdss_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic [mdss_pkg::IDX_W-1:0]      common_q, common_d;
  logic                            active_q, active_d;
  logic                            is_last;
  logic                            take;

  assign is_last    = (cnt_q == mdss_pkg::CNT_W'(mdss_pkg::TOTAL_BITS - 1));
  assign take       = active_q && pop;
  assign entry_rd_o = (!active_q || (take && is_last)) && entry_valid_i;

  assign empty           = !active_q;
  assign serial_bit_o    = shift_q[0];
  assign last_o          = is_last;
  assign common_select_o = is_last ? mdss_pkg::SEL_W'(common_q) : '0;

  always_comb begin
    shift_d  = shift_q;
    cnt_d    = cnt_q;
    common_d = common_q;
    active_d = active_q;
    if (take) begin
      shift_d = shift_q >> 1;
      if (is_last) begin
        cnt_d    = '0;
        active_d = 1'b0;
      end else begin
        cnt_d = cnt_q + mdss_pkg::CNT_W'(1);
      end
    end
    if (entry_rd_o) begin
      shift_d  = entry_i.words;
      cnt_d    = '0;
      common_d = entry_i.common;
      active_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q  <= shift_d;
    common_q <= common_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
    end
  end

  a_idle_cnt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (cnt_q == '0))
    else $error("bit counter not at start while idle");

  a_mid_beat_stays_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && !is_last) |=> active_q)
    else $error("scan dropped before its last bit");

endmodule

// File: rtl/multiplexed_display_scan_serializer_top.sv
// Multiplexed display scan serializer: write, commit and refresh-tick beats in,
// serial bit beats out. A tick yields 48 bit beats, one per cycle while pop is
// held high, through the back shifter; the first bit reaches the outputs once the
// scan entry has passed through the queue and been loaded into the back shifter.
// Up to two scans wait in the queue; full is high while it holds two.
// Reset clears both buffers, the common index and the pending flag.
module multiplexed_display_scan_serializer_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push,
  output logic                             full,
  input  logic [mdss_pkg::OP_W-1:0]        operation_i,
  input  logic [mdss_pkg::WORD_IDX_W-1:0]  word_index_i,
  input  logic [mdss_pkg::VALUE_W-1:0]     word_value_i,
  output logic                             empty,
  input  logic                             pop,
  output logic                             serial_bit_o,
  output logic [mdss_pkg::SEL_W-1:0]       common_select_o,
  output logic                             last_o
);

  logic            accept;
  logic            front_valid;
  mdss_pkg::scan_t front_entry;
  logic            q_valid;
  mdss_pkg::scan_t q_entry;
  logic            q_rd;

  assign accept = push && !full;

  mdss_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .operation_i   (operation_i),
    .word_index_i  (word_index_i),
    .word_value_i  (word_value_i),
    .entry_valid_o (front_valid),
    .entry_o       (front_entry)
  );

  mdss_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_valid),
    .wr_data_i (front_entry),
    .full_o    (full),
    .rd_i      (q_rd),
    .valid_o   (q_valid),
    .rd_data_o (q_entry)
  );

  mdss_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .entry_valid_i   (q_valid),
    .entry_i         (q_entry),
    .entry_rd_o      (q_rd),
    .empty           (empty),
    .pop             (pop),
    .serial_bit_o    (serial_bit_o),
    .common_select_o (common_select_o),
    .last_o          (last_o)
  );

endmodule
